FILE: src/lmts_pkg.sv
// Shared types, constants and font table for the 5x5 LED text scroller.
// No dependencies; imported by every module of the block.
package lmts_pkg;

   localparam int CODE_W    = 7;
   localparam int GLYPH_W   = 25;
   localparam int COLS      = 5;
   localparam int ROWS      = 5;
   localparam int FONT_SIZE = 1 << CODE_W;

   // Frame counter: six frames per character
   localparam logic [2:0] FRAME_FIRST = 3'd0;
   localparam logic [2:0] FRAME_LAST  = 3'd5;

   // Offsets of the slide-out and slide-in shifts
   localparam logic [2:0] PREV_SHIFT_BASE = 3'd2;
   localparam logic [2:0] NEXT_SHIFT_BASE = 3'd4;
   localparam logic [2:0] FINAL_SHIFT     = 3'd1;

   localparam logic [CODE_W-1:0] CODE_END = '0;

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic               code_zero;
   } glyph_type;

   typedef struct packed {
      logic [GLYPH_W-1:0] frame_bits;
      logic               last_frame;
      logic               text_done;
   } frame_type;

   // Bit 24 is row 0 column 0; row-major
   localparam logic [GLYPH_W-1:0] FONT_ROM [FONT_SIZE] = '{
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd8658952, 25'd10813440, 25'd11512810,
      25'd15514222, 25'd26808627, 25'd13185613, 25'd8650752,
      25'd4464900, 25'd8523912, 25'd332096, 25'd145536,
      25'd136, 25'd14336, 25'd256, 25'd1118480,
      25'd13191756, 25'd4591758, 25'd29438494, 25'd31527500,
      25'd6638562, 25'd33060926, 25'd2243118, 25'd32575760,
      25'd15252014, 25'd15251592, 25'd262400, 25'd131208,
      25'd2236546, 25'd459200, 25'd8521864, 25'd15243268,
      25'd0, 25'd13204050, 25'd29979228, 25'd15221262,
      25'd29968988, 25'd32010782, 25'd32010768, 25'd15224366,
      25'd19495506, 25'd29630748, 25'd32574028, 25'd19554962,
      25'd17318430, 25'd18732593, 25'd18667121, 25'd13191756,
      25'd29979152, 25'd13191558, 25'd29979217, 25'd15216732,
      25'd32641156, 25'd19483212, 25'd18400580, 25'd18405233,
      25'd19477074, 25'd18157700, 25'd31597086, 25'd0,
      25'd17043521, 25'd0, 25'd4521984, 25'd31,
      25'd8519680, 25'd477775, 25'd17330780, 25'd475662,
      25'd2177614, 25'd13201934, 25'd6582536, 25'd15284300,
      25'd17330770, 25'd8397064, 25'd2099276, 25'd17457810,
      25'd8659206, 25'd906801, 25'd936530, 25'd412236,
      25'd936848, 25'd477634, 25'd475664, 25'd204952,
      25'd8665351, 25'd608847, 25'd574788, 25'd575163,
      25'd602514, 25'd567448, 25'd987422, 25'd0,
      25'd8659208, 25'd0, 25'd12384, 25'd0
   };

   // Shift every row left by k columns; five or more clears the glyph
   function automatic logic [GLYPH_W-1:0] shift_left(input logic [GLYPH_W-1:0] g,
                                                     input logic [2:0] k);
      logic [GLYPH_W-1:0] res;
      logic [COLS-1:0]    row;
      res = '0;
      for (int r = 0; r < ROWS; r++) begin
         row = g[r*COLS +: COLS];
         res[r*COLS +: COLS] = (k >= 3'(COLS)) ? '0 : (row << k);
      end
      return res;
   endfunction

   // Shift every row right by k columns
   function automatic logic [GLYPH_W-1:0] shift_right(input logic [GLYPH_W-1:0] g,
                                                      input logic [2:0] k);
      logic [GLYPH_W-1:0] res;
      logic [COLS-1:0]    row;
      res = '0;
      for (int r = 0; r < ROWS; r++) begin
         row = g[r*COLS +: COLS];
         res[r*COLS +: COLS] = (k >= 3'(COLS)) ? '0 : (row >> k);
      end
      return res;
   endfunction

endpackage

FILE: src/led_matrix_text_scroller.sv
// Top level of the 5x5 LED matrix text scroller.
// Instantiates lmts_font_rom and lmts_frame_gen; uses lmts_pkg.
//
// Usage:
//  - req channel: one 7-bit character code per transfer (req_valid/req_stall).
//    Code 0 ends the text: its frames slide the last glyph out and the
//    stored glyph returns to blank.
//  - rsp channel: six transfers per character, each a 25-bit frame (bit 24
//    is the top-left LED, row-major), with rsp_last_frame on the sixth and
//    rsp_text_done on the sixth frame of an end-of-text run.
//  - Path: a character passes the font ROM read register, the frame
//    sequencer's glyph register and the output register.
//  - Throughput: one frame per cycle while rsp_stall is low; the frame
//    sequencer's six-step walk gives six per character. A second character
//    is taken into the ROM stage while the current one is being scrolled.
//  - rsp_stall freezes a full output register and the sequencer; req_stall
//    rises once the ROM stage holds a character the sequencer cannot take.
//  - Reset clears all valid flags and blanks the stored glyph.
module led_matrix_text_scroller
   import lmts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CODE_W-1:0]  req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [GLYPH_W-1:0] rsp_frame_bits,
   output logic               rsp_last_frame,
   output logic               rsp_text_done
);

   logic      glyph_valid, take, req_accept;
   glyph_type glyph;
   logic      frame_valid, out_ready;
   frame_type frame;

   logic      rsp_valid_ff, rsp_valid_in;
   frame_type rsp_data_ff;

   // ROM stage holds one character; stall while it cannot hand it on
   assign req_stall  = glyph_valid && !take;
   assign req_accept = req_valid && !req_stall;

   lmts_font_rom u_font_rom (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (req_accept),
      .rd_code     (req_char_code),
      .take        (take),
      .glyph_valid (glyph_valid),
      .glyph_out   (glyph)
   );

   // output register free or draining this cycle
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   lmts_frame_gen u_frame_gen (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (glyph_valid),
      .in_glyph    (glyph),
      .take        (take),
      .out_ready   (out_ready),
      .frame_valid (frame_valid),
      .frame_out   (frame)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) rsp_valid_in = frame_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds while stalled
   always_ff @(posedge clock) begin
      if (out_ready && frame_valid) begin
         rsp_data_ff <= frame;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_bits = rsp_data_ff.frame_bits;
   assign rsp_last_frame = rsp_data_ff.last_frame;
   assign rsp_text_done  = rsp_data_ff.text_done;

endmodule

FILE: src/lmts_font_rom.sv
// Font ROM stage: synchronous 128-entry glyph lookup with a registered read.
// Holds one looked-up character until the frame sequencer takes it. Uses lmts_pkg.
module lmts_font_rom
   import lmts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [CODE_W-1:0] rd_code,
   input  logic              take,
   output logic              glyph_valid,
   output glyph_type         glyph_out
);

   logic      valid_ff, valid_in;
   glyph_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b0;
      if (rd_en) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // registered ROM read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff.glyph     <= FONT_ROM[rd_code];
         data_ff.code_zero <= (rd_code == CODE_END);
      end
   end

   assign glyph_valid = valid_ff;
   assign glyph_out   = data_ff;

endmodule

FILE: src/lmts_frame_gen.sv
// Frame sequencer: walks six frames per character and keeps the shown glyph.
// Uses lmts_pkg shift functions and types.
module lmts_frame_gen
   import lmts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  glyph_type in_glyph,
   output logic      take,
   input  logic      out_ready,
   output logic      frame_valid,
   output frame_type frame_out
);

   logic               busy_ff, busy_in;
   logic [2:0]         idx_ff, idx_in;
   logic [GLYPH_W-1:0] cur_ff, cur_in;
   logic               zero_ff, zero_in;
   logic [GLYPH_W-1:0] prev_ff, prev_in;
   logic               emit, finish, is_last;

   assign is_last = (idx_ff == FRAME_LAST);
   assign emit    = busy_ff && out_ready;
   assign finish  = emit && is_last;
   assign take    = in_valid && (!busy_ff || finish);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      zero_in = zero_ff;
      prev_in = prev_ff;
      if (finish) prev_in = cur_ff;
      if (take) begin
         busy_in = 1'b1;
         idx_in  = FRAME_FIRST;
         cur_in  = in_glyph.glyph;
         zero_in = in_glyph.code_zero;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= FRAME_FIRST;
         prev_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (is_last) begin
         frame_out.frame_bits = shift_left(cur_ff, FINAL_SHIFT);
      end else begin
         frame_out.frame_bits = shift_left(prev_ff, PREV_SHIFT_BASE + idx_ff)
                              | shift_right(cur_ff, NEXT_SHIFT_BASE - idx_ff);
      end
      frame_out.last_frame = is_last;
      frame_out.text_done  = is_last && zero_ff;
   end

   assign frame_valid = busy_ff;

endmodule

FILE: verif/lmts_checker.sv
// Scoreboard for the 5x5 LED text scroller: predicts six frames per code transfer
// and compares every frame transfer against them. Depends on lmts_pkg for widths.
`timescale 1ns / 1ps

module lmts_checker
   import lmts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [CODE_W-1:0]  req_char_code,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [GLYPH_W-1:0] rsp_frame_bits,
   input  logic               rsp_last_frame,
   input  logic               rsp_text_done,
   output int                 fail_count,
   output int                 frames_pending
);

   localparam int FRAMES_PER_CODE = 6;

   // Independent copy of the font; bit 24 is the top-left LED
   localparam logic [GLYPH_W-1:0] GLYPH_FONT [128] = '{
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd8658952, 25'd10813440, 25'd11512810,
      25'd15514222, 25'd26808627, 25'd13185613, 25'd8650752,
      25'd4464900, 25'd8523912, 25'd332096, 25'd145536,
      25'd136, 25'd14336, 25'd256, 25'd1118480,
      25'd13191756, 25'd4591758, 25'd29438494, 25'd31527500,
      25'd6638562, 25'd33060926, 25'd2243118, 25'd32575760,
      25'd15252014, 25'd15251592, 25'd262400, 25'd131208,
      25'd2236546, 25'd459200, 25'd8521864, 25'd15243268,
      25'd0, 25'd13204050, 25'd29979228, 25'd15221262,
      25'd29968988, 25'd32010782, 25'd32010768, 25'd15224366,
      25'd19495506, 25'd29630748, 25'd32574028, 25'd19554962,
      25'd17318430, 25'd18732593, 25'd18667121, 25'd13191756,
      25'd29979152, 25'd13191558, 25'd29979217, 25'd15216732,
      25'd32641156, 25'd19483212, 25'd18400580, 25'd18405233,
      25'd19477074, 25'd18157700, 25'd31597086, 25'd0,
      25'd17043521, 25'd0, 25'd4521984, 25'd31,
      25'd8519680, 25'd477775, 25'd17330780, 25'd475662,
      25'd2177614, 25'd13201934, 25'd6582536, 25'd15284300,
      25'd17330770, 25'd8397064, 25'd2099276, 25'd17457810,
      25'd8659206, 25'd906801, 25'd936530, 25'd412236,
      25'd936848, 25'd477634, 25'd475664, 25'd204952,
      25'd8665351, 25'd608847, 25'd574788, 25'd575163,
      25'd602514, 25'd567448, 25'd987422, 25'd0,
      25'd8659208, 25'd0, 25'd12384, 25'd0
   };

   frame_type          expected_frames[$];
   logic [GLYPH_W-1:0] shown_glyph = '0;
   int                 mismatches  = 0;

   initial begin
      fail_count     = 0;
      frames_pending = 0;
   end

   // Moves each 5-bit row by k columns; k of 5 or more empties the glyph
   function automatic logic [GLYPH_W-1:0] slide_cols(input logic [GLYPH_W-1:0] g,
                                                     input int k, input bit to_left);
      logic [GLYPH_W-1:0] res;
      logic [4:0]         row;
      res = '0;
      if (k >= 5) return res;
      for (int r = 0; r < 5; r++) begin
         row = g[20-5*r +: 5];
         row = to_left ? (row << k) : (row >> k);
         res[20-5*r +: 5] = row;
      end
      return res;
   endfunction

   task automatic predict_scroll(input logic [CODE_W-1:0] code);
      logic [GLYPH_W-1:0] incoming;
      frame_type          f;
      incoming = GLYPH_FONT[code];
      for (int s = 0; s < FRAMES_PER_CODE; s++) begin
         if (s == FRAMES_PER_CODE - 1)
            f.frame_bits = slide_cols(incoming, 1, 1'b1);
         else
            f.frame_bits = slide_cols(shown_glyph, 2 + s, 1'b1) |
                           slide_cols(incoming, 4 - s, 1'b0);
         f.last_frame = (s == FRAMES_PER_CODE - 1);
         f.text_done  = (s == FRAMES_PER_CODE - 1) && (code == CODE_END);
         expected_frames.push_back(f);
      end
      shown_glyph = (code == CODE_END) ? '0 : incoming;
   endtask

   task automatic compare_frame();
      frame_type want;
      if (expected_frames.size() == 0) begin
         $error("unexpected frame transfer: frame_bits %h", rsp_frame_bits);
         mismatches++;
         return;
      end
      want = expected_frames.pop_front();
      if (rsp_frame_bits !== want.frame_bits) begin
         $error("frame_bits: expected %h, got %h", want.frame_bits, rsp_frame_bits);
         mismatches++;
      end
      if (rsp_last_frame !== want.last_frame) begin
         $error("last_frame: expected %b, got %b", want.last_frame, rsp_last_frame);
         mismatches++;
      end
      if (rsp_text_done !== want.text_done) begin
         $error("text_done: expected %b, got %b", want.text_done, rsp_text_done);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shown_glyph = '0;
         expected_frames.delete();
      end else begin
         if (req_valid && !req_stall) predict_scroll(req_char_code);
         if (rsp_valid && !rsp_stall) compare_frame();
      end
      frames_pending <= expected_frames.size();
      fail_count     <= mismatches;
   end

endmodule

FILE: verif/testbench.sv
// Top of the LED text scroller testbench: clock, reset, code stimulus, frame
// back-pressure, watchdog and verdict. Needs lmts_pkg, the block and lmts_checker.
`timescale 1ns / 1ps

module testbench;
   import lmts_pkg::*;

   // Longest quiet stretch tolerated; the deliberate hold-off is far shorter
   localparam int QUIET_LIMIT = 2000;
   // Length of the receiver hold-off used to fill the pipeline
   localparam int HOLD_CYCLES = 300;
   // Margin kept after the last predicted frame has been compared
   localparam int DRAIN_CYCLES = 12;

   // Directed codes: end of text with nothing shown, all-ones code, codes
   // without a glyph, digits, letters, the underscore (bottom row only),
   // back-to-back end-of-text, then text again after a blank restart
   localparam int N_DIRECTED = 18;
   localparam logic [CODE_W-1:0] DIRECTED_CODES [N_DIRECTED] = '{
      7'd0, 7'd127, 7'd1, 7'd32, 7'd48, 7'd65, 7'd77, 7'd87, 7'd95,
      7'd126, 7'd122, 7'd103, 7'd0, 7'd0, 7'd35, 7'd56, 7'd64, 7'd0
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CODE_W-1:0]  req_char_code = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [GLYPH_W-1:0] rsp_frame_bits;
   logic               rsp_last_frame;
   logic               rsp_text_done;

   int fail_count;
   int frames_pending;

   // Idle knobs, in percent per cycle
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Hold-off handshake between stimulus and receiver processes
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   led_matrix_text_scroller dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_bits (rsp_frame_bits),
      .rsp_last_frame (rsp_last_frame),
      .rsp_text_done  (rsp_text_done)
   );

   lmts_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_bits (rsp_frame_bits),
      .rsp_last_frame (rsp_last_frame),
      .rsp_text_done  (rsp_text_done),
      .fail_count     (fail_count),
      .frames_pending (frames_pending)
   );

   // Frame receiver: a pending hold-off request wins over random stalls.
   // The hold-off is counted here so the sender keeps offering codes meanwhile.
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         hold_left = HOLD_CYCLES;
         holds_served++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: any transfer on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One code transfer. Random idle cycles go in front; once valid is up it
   // stays up, with the payload frozen, until the block takes it.
   task automatic send_code(input logic [CODE_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly words of printable characters closed by end-of-text, with a
   // sprinkle of arbitrary codes (control codes, DEL, stray end markers)
   task automatic send_text(input int count);
      int                word_left;
      logic [CODE_W-1:0] code;
      word_left = $urandom_range(8, 1);
      repeat (count) begin
         if ($urandom_range(9) == 0) begin
            code = CODE_W'($urandom_range(127, 0));
         end else if (word_left == 0) begin
            code      = CODE_END;
            word_left = $urandom_range(8, 1);
         end else begin
            code = CODE_W'($urandom_range(126, 32));
            word_left--;
         end
         send_code(code);
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct <= send_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at full rate
      foreach (DIRECTED_CODES[i]) send_code(DIRECTED_CODES[i]);

      // Random part across the idle mixes
      set_idling(0, 0);
      send_text(25);
      set_idling(55, 0);
      send_text(25);
      set_idling(0, 55);
      send_text(25);
      set_idling(18, 18);
      send_text(25);

      // Back-pressure: receiver holds off while codes keep coming
      set_idling(0, 0);
      hold_requests <= hold_requests + 1;
      send_text(20);

      req_valid <= 1'b0;
      // Advance the clock so the pending count includes the final transfer
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && frames_pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
